// ===== design/lmts_pkg.sv =====
`default_nettype none

package lmts_pkg;

    localparam int unsigned VISIBLE_LINES = 144;

    localparam int unsigned OAM_CYCLES    = 80;
    localparam int unsigned XFER_CYCLES   = 172;
    localparam int unsigned HBLANK_CYCLES = 204;
    localparam int unsigned LINE_CYCLES   = 456;
    localparam int unsigned VBLANK_CYCLES = 4560;

    localparam int DOT_W  = 13;
    localparam int LINE_W = 8;
    localparam int IRQ_W  = 4;

    // largest quotient the dot counter can reach for any of the mode lengths
    localparam int QUOT_MAX = 10;
    localparam int QUOT_W   = $clog2(QUOT_MAX + 1);

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic CFG_DISPLAY_ENABLE = 1'b0;
    localparam logic CFG_LINE_COMPARE   = 1'b1;

    // enable bits
    localparam int IRQ_HBL  = 0;
    localparam int IRQ_VBL  = 1;
    localparam int IRQ_OAM  = 2;
    localparam int IRQ_COIN = 3;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] cycles;
        logic       stop_mode;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        mode_t             current_mode;
        logic [LINE_W-1:0] current_line;
        logic [6:0]        status_value;
        logic              vblank_request;
        logic              status_request;
        logic              line_done;
        logic [LINE_W-1:0] finished_line;
        logic              frame_done;
    } result_t;

    // quotient by a constant through parallel threshold compares
    function automatic logic [QUOT_W-1:0] dot_quot(input logic [DOT_W-1:0] x,
                                                   input int unsigned c);
        logic [QUOT_W-1:0] q;
        q = '0;
        for (int k = 1; k <= QUOT_MAX; k++) begin
            if (32'(x) >= 32'(k) * c) begin
                q = QUOT_W'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [DOT_W-1:0] dot_rem(input logic [DOT_W-1:0] x,
                                                 input int unsigned c);
        logic [QUOT_W-1:0] q;
        q = dot_quot(x, c);
        return x - DOT_W'(32'(q) * c);
    endfunction

endpackage

`default_nettype wire

// ===== design/lmts_item_if.sv =====
`default_nettype none

interface lmts_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] cycles;
    logic       stop_mode;
    logic [7:0] write_data;

    modport source (
        output valid,
        output operation,
        output cycles,
        output stop_mode,
        output write_data,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  cycles,
        input  stop_mode,
        input  write_data,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/lmts_result_if.sv =====
`default_nettype none

interface lmts_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] current_mode;
    logic [7:0] current_line;
    logic [6:0] status_value;
    logic       vblank_request;
    logic       status_request;
    logic       line_done;
    logic [7:0] finished_line;
    logic       frame_done;

    modport source (
        output valid,
        output current_mode,
        output current_line,
        output status_value,
        output vblank_request,
        output status_request,
        output line_done,
        output finished_line,
        output frame_done,
        input  ready
    );

    modport sink (
        input  valid,
        input  current_mode,
        input  current_line,
        input  status_value,
        input  vblank_request,
        input  status_request,
        input  line_done,
        input  finished_line,
        input  frame_done,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/lmts_in_reg.sv =====
`default_nettype none

module lmts_in_reg
    import lmts_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lmts_item_if.sink   item,
    input  wire logic   take,
    output stage_t      stage
);

    logic  valid_reg;
    item_t item_reg;
    logic  accept;

    assign item.ready = !valid_reg || take;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation  <= item.operation;
            item_reg.cycles     <= item.cycles;
            item_reg.stop_mode  <= item.stop_mode;
            item_reg.write_data <= item.write_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

// ===== design/lmts_core.sv =====
`default_nettype none

module lmts_core
    import lmts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic       wr_index,
    input  wire logic [7:0] wr_data,
    input  stage_t          stage,
    output logic            take,
    lmts_result_if.source   result
);

    logic              display_enable_reg;
    logic [LINE_W-1:0] line_compare_reg;

    mode_t             mode_reg, mode_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [IRQ_W-1:0]  irq_reg, irq_next;

    logic              res_valid_reg;
    result_t           result_reg, result_next;

    logic [DOT_W-1:0]  dot_sum;
    logic [LINE_W-1:0] line_inc;
    logic [LINE_W-1:0] vbl_line;
    logic              tick;
    logic              dot_in_range;

    assign take = stage.valid && (!res_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg <= 1'b0;
            line_compare_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_DISPLAY_ENABLE: display_enable_reg <= wr_data[0];
                CFG_LINE_COMPARE:   line_compare_reg   <= wr_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HBLANK;
            line_reg <= '0;
            dot_reg  <= '0;
            irq_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            dot_reg  <= dot_next;
            irq_reg  <= irq_next;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        dot_next  = dot_reg;
        irq_next  = irq_reg;

        result_next = '0;

        dot_sum  = dot_reg + DOT_W'(stage.item.cycles);
        line_inc = line_reg + LINE_W'(1);
        vbl_line = LINE_W'(VISIBLE_LINES + 32'(dot_quot(dot_sum, LINE_CYCLES)));
        tick     = (stage.item.operation == OP_TICK) && !stage.item.stop_mode
                   && display_enable_reg;

        if (stage.item.operation == OP_WRITE)
        begin
            irq_next = stage.item.write_data[6:3];
        end
        else if (tick)
        begin
            unique case (mode_reg)
                MODE_HBLANK:
                begin
                    dot_next = dot_sum;
                    if (dot_sum >= DOT_W'(HBLANK_CYCLES))
                    begin
                        result_next.line_done     = 1'b1;
                        result_next.finished_line = line_reg;
                        dot_next  = dot_rem(dot_sum, HBLANK_CYCLES);
                        line_next = line_inc;
                        if (32'(line_inc) < VISIBLE_LINES)
                        begin
                            mode_next = MODE_OAM;
                            result_next.status_request = irq_reg[IRQ_OAM];
                        end
                        else
                        begin
                            mode_next = MODE_VBLANK;
                            result_next.vblank_request = 1'b1;
                            result_next.status_request = irq_reg[IRQ_VBL];
                        end
                        if (irq_reg[IRQ_COIN] && (line_inc == line_compare_reg))
                        begin
                            result_next.status_request = 1'b1;
                        end
                    end
                end
                MODE_VBLANK:
                begin
                    if (dot_sum >= DOT_W'(VBLANK_CYCLES))
                    begin
                        result_next.frame_done = 1'b1;
                        dot_next  = dot_rem(dot_sum, VBLANK_CYCLES);
                        line_next = '0;
                        mode_next = MODE_OAM;
                        result_next.status_request = irq_reg[IRQ_OAM]
                            || (irq_reg[IRQ_COIN] && (line_compare_reg == '0));
                    end
                    else
                    begin
                        dot_next  = dot_sum;
                        line_next = vbl_line;
                        result_next.status_request = (vbl_line != line_reg)
                            && irq_reg[IRQ_COIN] && (vbl_line == line_compare_reg);
                    end
                end
                MODE_OAM:
                begin
                    dot_next = dot_sum;
                    if (dot_sum >= DOT_W'(OAM_CYCLES))
                    begin
                        dot_next  = dot_rem(dot_sum, OAM_CYCLES);
                        mode_next = MODE_XFER;
                    end
                end
                MODE_XFER:
                begin
                    dot_next = dot_sum;
                    if (dot_sum >= DOT_W'(XFER_CYCLES))
                    begin
                        dot_next  = dot_rem(dot_sum, XFER_CYCLES);
                        mode_next = MODE_HBLANK;
                        result_next.status_request = irq_reg[IRQ_HBL];
                    end
                end
                default: ;
            endcase
        end

        result_next.current_mode = mode_next;
        result_next.current_line = line_next;
        result_next.status_value = {irq_next, (line_next == line_compare_reg), mode_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.current_mode   = result_reg.current_mode;
    assign result.current_line   = result_reg.current_line;
    assign result.status_value   = result_reg.status_value;
    assign result.vblank_request = result_reg.vblank_request;
    assign result.status_request = result_reg.status_request;
    assign result.line_done      = result_reg.line_done;
    assign result.finished_line  = result_reg.finished_line;
    assign result.frame_done     = result_reg.frame_done;

    // reachable counter range per mode; the threshold divides rely on it
    assign dot_in_range = ((mode_reg == MODE_HBLANK) && (dot_reg < DOT_W'(HBLANK_CYCLES)))
                       || ((mode_reg == MODE_OAM)    && (dot_reg < DOT_W'(255)))
                       || ((mode_reg == MODE_XFER)   && (dot_reg < DOT_W'(XFER_CYCLES)))
                       || ((mode_reg == MODE_VBLANK) && (dot_reg < DOT_W'(VBLANK_CYCLES)));

    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n) dot_in_range)
        else $error("dot counter out of range for mode");

    a_line_done_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && result_reg.line_done |->
            (result_reg.current_mode == MODE_OAM) || (result_reg.current_mode == MODE_VBLANK))
        else $error("line done without entering oam or vblank");

    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && result_reg.frame_done |->
            (result_reg.current_mode == MODE_OAM) && (result_reg.current_line == '0)
            && !result_reg.line_done)
        else $error("frame done with wrong mode or line");

    a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && result_reg.vblank_request |->
            (result_reg.current_mode == MODE_VBLANK)
            && (result_reg.current_line == LINE_W'(VISIBLE_LINES)) && result_reg.line_done)
        else $error("vblank request outside vblank entry");

endmodule

`default_nettype wire

// ===== design/lcd_mode_timing_stat.sv =====
// Display timing engine with status register.
//
// item:   operation/cycles/stop_mode/write_data, valid/ready. A tick advances
//         the dot counter through OAM search, transfer, H-blank and V-blank;
//         a write loads the four interrupt enables; a read changes nothing.
// result: one transfer per item, in order: mode, line, status byte, the
//         vblank and status requests, line_done with finished_line, frame_done.
// wr_en/wr_index/wr_data: index 0 display enable (bit 0), index 1 line compare.
//         Write only while no item is in flight.
//
// The item is captured in the input register, and the result register is then
// loaded from the mode/counter update when the core takes the item. While
// result.ready is high, throughput is one item per cycle.
// Reset clears mode to H-blank, line, dot counter, enables and both config
// registers; nothing is held in flight. When result.ready is low the result
// holds, one more item is taken into the input register, and item.ready then
// drops until the result is transferred.
`default_nettype none

module lcd_mode_timing_stat
    import lmts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    lmts_item_if.sink       item,
    lmts_result_if.source   result,
    input  wire logic       wr_en,
    input  wire logic       wr_index,
    input  wire logic [7:0] wr_data
);

    stage_t stage;
    logic   take;

    lmts_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .stage (stage)
    );

    lmts_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .stage    (stage),
        .take     (take),
        .result   (result)
    );

endmodule

`default_nettype wire

// ===== tb/lmts_stat_checker.sv =====
`default_nettype none

module lmts_stat_checker
    import lmts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lmts_item_if       item,
    lmts_result_if     result,
    input  logic       wr_en,
    input  logic       wr_index,
    input  logic [7:0] wr_data,
    output int         fail_count,
    output int         pending
);

    localparam int unsigned SHOWN_LINES = 144;
    localparam int unsigned OAM_LEN     = 80;
    localparam int unsigned XFER_LEN    = 172;
    localparam int unsigned HBL_LEN     = 204;
    localparam int unsigned LINE_LEN    = 456;
    localparam int unsigned VBL_LEN     = 4560;

    logic        disp_en;
    logic [7:0]  line_cmp;
    mode_t       mode;
    logic [7:0]  line;
    logic [12:0] dots;
    logic [3:0]  irq_en;
    result_t     expected_q[$];

    function automatic string fmt(input result_t r);
        return $sformatf("mode %0d line %0d stat %h vreq %b sreq %b ldone %b fline %0d fdone %b",
                         r.current_mode, r.current_line, r.status_value, r.vblank_request,
                         r.status_request, r.line_done, r.finished_line, r.frame_done);
    endfunction

    task automatic advance_timing(input logic [1:0] op, input logic [7:0] cyc,
                                  input logic stop, input logic [7:0] wd,
                                  output result_t r);
        logic [7:0] prev;
        r = '0;
        if (op == OP_WRITE)
        begin
            irq_en = wd[6:3];
        end
        else if (op == OP_TICK && !stop && disp_en)
        begin
            dots = dots + 13'(cyc);
            case (mode)
                MODE_HBLANK:
                begin
                    if (dots >= HBL_LEN)
                    begin
                        r.line_done = 1'b1;
                        r.finished_line = line;
                        dots = 13'(dots % HBL_LEN);
                        line = line + 8'd1;
                        if (line < SHOWN_LINES)
                        begin
                            mode = MODE_OAM;
                            if (irq_en[IRQ_OAM]) r.status_request = 1'b1;
                        end
                        else
                        begin
                            mode = MODE_VBLANK;
                            r.vblank_request = 1'b1;
                            if (irq_en[IRQ_VBL]) r.status_request = 1'b1;
                        end
                        if (irq_en[IRQ_COIN] && line == line_cmp) r.status_request = 1'b1;
                    end
                end
                MODE_VBLANK:
                begin
                    prev = line;
                    line = 8'(SHOWN_LINES + dots / LINE_LEN);
                    if (dots >= VBL_LEN)
                    begin
                        r.frame_done = 1'b1;
                        dots = 13'(dots % VBL_LEN);
                        line = '0;
                        mode = MODE_OAM;
                        if (irq_en[IRQ_OAM]) r.status_request = 1'b1;
                        if (irq_en[IRQ_COIN] && line == line_cmp) r.status_request = 1'b1;
                    end
                    else if (line != prev)
                    begin
                        if (irq_en[IRQ_COIN] && line == line_cmp) r.status_request = 1'b1;
                    end
                end
                MODE_OAM:
                begin
                    if (dots >= OAM_LEN)
                    begin
                        dots = 13'(dots % OAM_LEN);
                        mode = MODE_XFER;
                    end
                end
                default:
                begin
                    if (dots >= XFER_LEN)
                    begin
                        dots = 13'(dots % XFER_LEN);
                        mode = MODE_HBLANK;
                        if (irq_en[IRQ_HBL]) r.status_request = 1'b1;
                    end
                end
            endcase
        end
        r.current_mode = mode;
        r.current_line = line;
        r.status_value = {irq_en, line == line_cmp, mode};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t predicted;
        result_t observed;
        result_t oldest;
        logic    bad;
        if (!rst_n)
        begin
            disp_en = 1'b0;
            line_cmp = '0;
            mode = MODE_HBLANK;
            line = '0;
            dots = '0;
            irq_en = '0;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == CFG_DISPLAY_ENABLE) disp_en = wr_data[0];
                else line_cmp = wr_data;
            end
            if (item.valid && item.ready)
            begin
                advance_timing(item.operation, item.cycles, item.stop_mode, item.write_data,
                               predicted);
                expected_q.push_back(predicted);
            end
            if (result.valid && result.ready)
            begin
                observed.current_mode   = mode_t'(result.current_mode);
                observed.current_line   = result.current_line;
                observed.status_value   = result.status_value;
                observed.vblank_request = result.vblank_request;
                observed.status_request = result.status_request;
                observed.line_done      = result.line_done;
                observed.finished_line  = result.finished_line;
                observed.frame_done     = result.frame_done;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %s", fmt(observed));
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    bad = (observed.current_mode !== oldest.current_mode)
                       || (observed.current_line !== oldest.current_line)
                       || (observed.status_value !== oldest.status_value)
                       || (observed.vblank_request !== oldest.vblank_request)
                       || (observed.status_request !== oldest.status_request)
                       || (observed.line_done !== oldest.line_done)
                       || (observed.finished_line !== oldest.finished_line)
                       || (observed.frame_done !== oldest.frame_done);
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result mismatch");
                            $display("  expected %s", fmt(oldest));
                            $display("  actual   %s", fmt(observed));
                        end
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/lcd_mode_timing_stat_test.sv =====
`default_nettype none

module lcd_mode_timing_stat_test;
    import lmts_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD = 64;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       wr_en;
    logic       wr_index;
    logic [7:0] wr_data;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    logic       hold_long = 1'b0;

    lmts_item_if   item_ch();
    lmts_result_if result_ch();

    lcd_mode_timing_stat dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    lmts_stat_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short, now and then long
    function automatic int pick_len(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] cyc,
                             input logic stop, input logic [7:0] wd);
        int gap;
        gap = pick_len(gap_pct);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= op;
        item_ch.cycles     <= cyc;
        item_ch.stop_mode  <= stop;
        item_ch.write_data <= wd;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic write_regs(input logic en, input logic [7:0] cmp);
        wr_en    <= 1'b1;
        wr_index <= CFG_DISPLAY_ENABLE;
        wr_data  <= {7'd0, en};
        @(posedge clk);
        wr_index <= CFG_LINE_COMPARE;
        wr_data  <= cmp;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            int len;
            @(posedge clk);
            len = pick_len(stall_pct);
            if (hold_long)
            begin
                hold_long = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (len > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (len) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("lcd_mode_timing_stat_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int         n_items;
        int         r;
        logic       en;
        logic [7:0] cmp;
        logic [1:0] op;
        rst_n              <= 1'b0;
        wr_en              <= 1'b0;
        wr_index           <= CFG_DISPLAY_ENABLE;
        wr_data            <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.operation  <= OP_TICK;
        item_ch.cycles     <= '0;
        item_ch.stop_mode  <= 1'b0;
        item_ch.write_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // display off: ticks frozen, status ops still answered
        write_regs(1'b0, 8'hFF);
        send_item(OP_TICK, 8'hFF, 1'b0, 8'h00);
        send_item(OP_WRITE, 8'h00, 1'b0, 8'hFF);
        send_item(OP_READ, 8'h00, 1'b0, 8'h00);
        send_item(OP_UNUSED, 8'hFF, 1'b1, 8'hFF);
        wait_idle();

        write_regs(1'b1, 8'h00);
        send_item(OP_TICK, 8'hFF, 1'b1, 8'h00);
        send_item(OP_TICK, 8'h00, 1'b0, 8'h00);
        send_item(OP_WRITE, 8'h00, 1'b0, 8'h78);
        send_item(OP_TICK, 8'd203, 1'b0, 8'h00);
        send_item(OP_TICK, 8'd1, 1'b0, 8'h00);
        send_item(OP_TICK, 8'd79, 1'b0, 8'h00);
        send_item(OP_TICK, 8'd1, 1'b0, 8'h00);
        send_item(OP_TICK, 8'hFF, 1'b0, 8'h00);
        send_item(OP_READ, 8'h00, 1'b0, 8'h00);
        send_item(OP_WRITE, 8'h00, 1'b0, 8'h87);
        send_item(OP_TICK, 8'hFF, 1'b0, 8'h00);
        send_item(OP_TICK, 8'h00, 1'b0, 8'h00);
        send_item(OP_UNUSED, 8'h00, 1'b0, 8'h00);
        send_item(OP_WRITE, 8'h00, 1'b0, 8'h78);

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            n_items = 130;
            en = 1'b1;
            case (p)
                0:
                begin
                    cmp = 8'h00;
                    gap_pct = 30;
                    stall_pct = 30;
                end
                1:
                begin
                    cmp = 8'($urandom_range(1, 143));
                    gap_pct = 0;
                    stall_pct = 0;
                    hold_long = 1'b1;
                end
                2:
                begin
                    en = 1'b0;
                    cmp = 8'hFF;
                    n_items = 30;
                    gap_pct = 30;
                    stall_pct = 20;
                end
                3:
                begin
                    cmp = 8'($urandom_range(144, 153));
                    gap_pct = 20;
                    stall_pct = 40;
                end
                default:
                begin
                    cmp = 8'($urandom);
                    gap_pct = 40;
                    stall_pct = 10;
                end
            endcase
            write_regs(en, cmp);
            repeat (n_items)
            begin
                r = $urandom_range(99);
                if (r < 80) op = OP_TICK;
                else if (r < 88) op = OP_WRITE;
                else if (r < 96) op = OP_READ;
                else op = OP_UNUSED;
                send_item(op,
                          ($urandom_range(99) < 80) ? 8'($urandom_range(224, 255)) : 8'($urandom),
                          $urandom_range(99) < 5, 8'($urandom));
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("lcd_mode_timing_stat_test: PASS");
        else
            $display("lcd_mode_timing_stat_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/lmts_pkg.sv
design/lmts_item_if.sv
design/lmts_result_if.sv
design/lmts_in_reg.sv
design/lmts_core.sv
design/lcd_mode_timing_stat.sv
tb/lmts_stat_checker.sv
tb/lcd_mode_timing_stat_test.sv
